[hw/rtl/plid_pkg.sv]
// Package for the positional list insert/delete block: widths, codes and the
// control struct that the top level hands to every storage cell.
// No dependencies.
`default_nettype none

package plid_pkg;

  // field widths of the command and result channels
  localparam int POS_W        = 5;
  localparam int DATA_W       = 32;
  localparam int LEN_W        = 5;
  localparam int STATUS_W     = 2;

  // default number of list entries
  localparam int CAPACITY_DEF = 16;

  // mode codes of a command
  localparam logic MODE_INSERT = 1'b0;
  localparam logic MODE_DELETE = 1'b1;

  // result status codes
  typedef enum logic [STATUS_W-1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  // what every cell does this cycle
  typedef enum logic [1:0] {
    CMD_HOLD   = 2'd0,
    CMD_INSERT = 2'd1,
    CMD_DELETE = 2'd2
  } cell_cmd_t;

  // broadcast to the row of cells: command and zero-based slot
  typedef struct packed {
    cell_cmd_t          cmd;
    logic [POS_W-1:0]   slot;
  } cell_ctl_t;

endpackage

`default_nettype wire

[hw/rtl/plid_cell.sv]
// One storage cell of the list: holds a single entry and takes the new entry,
// or that of its left or right neighbor, when the list opens or closes at or below it.
// Depends on plid_pkg.
`default_nettype none

module plid_cell #(
  parameter int unsigned INDEX = 0,
  parameter int          IDX_W = 4
) (
  input  wire                           clk,
  input  wire  plid_pkg::cell_ctl_t     ctl_i,
  input  wire  [plid_pkg::DATA_W-1:0]   ins_data_i,
  input  wire  [plid_pkg::DATA_W-1:0]   left_i,
  input  wire  [plid_pkg::DATA_W-1:0]   right_i,
  output logic [plid_pkg::DATA_W-1:0]   data_o
);

  localparam int CMP_W = ((IDX_W > plid_pkg::POS_W) ? IDX_W : plid_pkg::POS_W) + 1;

  logic [plid_pkg::DATA_W-1:0] data_r;
  logic [plid_pkg::DATA_W-1:0] data_nxt;
  logic [CMP_W-1:0]            slot_c;
  logic [CMP_W-1:0]            idx_c;
  logic                        at_slot;
  logic                        past_slot;

  // where this cell sits relative to the addressed slot
  assign slot_c    = CMP_W'(ctl_i.slot);
  assign idx_c     = CMP_W'(INDEX);
  assign at_slot   = (idx_c == slot_c);
  assign past_slot = (idx_c > slot_c);

  // open a gap on insert, close it on delete
  always_comb begin
    data_nxt = data_r;
    case (ctl_i.cmd)
      plid_pkg::CMD_INSERT: begin
        if (at_slot) begin
          data_nxt = ins_data_i;
        end else if (past_slot) begin
          data_nxt = left_i;
        end
      end
      plid_pkg::CMD_DELETE: begin
        if (at_slot || past_slot) begin
          data_nxt = right_i;
        end
      end
      default: begin
        data_nxt = data_r;
      end
    endcase
  end

  // entry storage, no reset
  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o = data_r;

endmodule

`default_nettype wire

[hw/rtl/positional_list_insert_delete.sv]
// Top level of the positional list insert/delete block: range checks, length
// counter, result register and the row of plid_cell storage cells.
// Depends on plid_pkg and plid_cell.
//
//  channel   ports                                    transfer
//  --------  ---------------------------------------  ---------------------------
//  command   start, busy, in_mode/position/value      start high while busy low
//  result    out_valid, out_status/removed_value/     out_valid high, one cycle,
//            out_list_length                          receiver cannot hold it off
//
// One command per cycle: every cell shifts with its neighbor in the same cycle,
// so a command is done in the cycle it is taken and its result shows on the
// next cycle for exactly one cycle. busy stays low.
// Reset clears the length and the result strobe only; entries are written before they are read.
`default_nettype none

module positional_list_insert_delete #(
  parameter int CAPACITY = plid_pkg::CAPACITY_DEF
) (
  input  wire                                  clk,
  input  wire                                  rst_n,
  input  wire                                  start,
  output logic                                 busy,
  input  wire                                  in_mode,
  input  wire         [plid_pkg::POS_W-1:0]    in_position,
  input  wire  signed [plid_pkg::DATA_W-1:0]   in_value,
  output logic                                 out_valid,
  output logic        [plid_pkg::STATUS_W-1:0] out_status,
  output logic signed [plid_pkg::DATA_W-1:0]   out_removed_value,
  output logic        [plid_pkg::LEN_W-1:0]    out_list_length
);

  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CMP_W = ((CNT_W > plid_pkg::POS_W) ? CNT_W : plid_pkg::POS_W) + 1;

  logic                          accept;
  logic [CNT_W-1:0]              count_r;
  logic [CNT_W-1:0]              count_nxt;
  logic [CMP_W-1:0]              pos_w;
  logic [CMP_W-1:0]              cnt_w;
  logic [CMP_W-1:0]              slot_w;
  logic [CMP_W-1:0]              cnt_nxt_w;
  logic                          ins_pos_ok;
  logic                          del_pos_ok;
  logic                          full;
  plid_pkg::status_t             status;
  plid_pkg::cell_ctl_t           ctl;
  logic [plid_pkg::DATA_W-1:0]   cell_q [CAPACITY];
  logic [plid_pkg::DATA_W-1:0]   rd_data;
  logic [plid_pkg::DATA_W-1:0]   removed;

  logic                          out_valid_r;
  logic [plid_pkg::STATUS_W-1:0] out_status_r;
  logic [plid_pkg::DATA_W-1:0]   out_removed_r;
  logic [plid_pkg::LEN_W-1:0]    out_length_r;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  // position checks against the current length
  assign pos_w      = CMP_W'(in_position);
  assign cnt_w      = CMP_W'(count_r);
  assign slot_w     = pos_w - CMP_W'(1);
  assign ins_pos_ok = (pos_w != '0) && (pos_w <= cnt_w + CMP_W'(1));
  assign del_pos_ok = (pos_w != '0) && (pos_w <= cnt_w);
  assign full       = (cnt_w == CMP_W'(CAPACITY));

  // entry at the addressed slot, for a delete
  assign rd_data = cell_q[slot_w[IDX_W-1:0]];

  // command decode, cell control and next length
  always_comb begin
    status    = plid_pkg::ST_OK;
    removed   = '0;
    count_nxt = count_r;
    ctl.cmd   = plid_pkg::CMD_HOLD;
    ctl.slot  = in_position - plid_pkg::POS_W'(1);
    if (in_mode == plid_pkg::MODE_INSERT) begin
      if (!ins_pos_ok) begin
        status = plid_pkg::ST_BADPOS;
      end else if (full) begin
        status = plid_pkg::ST_FULL;
      end else begin
        count_nxt = count_r + CNT_W'(1);
        ctl.cmd   = accept ? plid_pkg::CMD_INSERT : plid_pkg::CMD_HOLD;
      end
    end else begin
      if (!del_pos_ok) begin
        status = plid_pkg::ST_BADPOS;
      end else begin
        removed   = rd_data;
        count_nxt = count_r - CNT_W'(1);
        ctl.cmd   = accept ? plid_pkg::CMD_DELETE : plid_pkg::CMD_HOLD;
      end
    end
  end

  assign cnt_nxt_w = CMP_W'(count_nxt);

  // row of cells, each wired to its neighbors
  for (genvar gi = 0; gi < CAPACITY; gi++) begin : g_cell
    logic [plid_pkg::DATA_W-1:0] left_d;
    logic [plid_pkg::DATA_W-1:0] right_d;

    if (gi == 0) begin : g_first
      assign left_d = in_value;
    end else begin : g_mid_l
      assign left_d = cell_q[gi-1];
    end

    if (gi == CAPACITY - 1) begin : g_last
      assign right_d = cell_q[gi];
    end else begin : g_mid_r
      assign right_d = cell_q[gi+1];
    end

    plid_cell #(
      .INDEX (gi),
      .IDX_W (IDX_W)
    ) u_cell (
      .clk        (clk),
      .ctl_i      (ctl),
      .ins_data_i (in_value),
      .left_i     (left_d),
      .right_i    (right_d),
      .data_o     (cell_q[gi])
    );
  end

  // length counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (accept) begin
      count_r <= count_nxt;
    end
  end

  // result strobe
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= accept;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_status_r  <= status;
      out_removed_r <= removed;
      out_length_r  <= cnt_nxt_w[plid_pkg::LEN_W-1:0];
    end
  end

  assign out_valid         = out_valid_r;
  assign out_status        = out_status_r;
  assign out_removed_value = out_removed_r;
  assign out_list_length   = out_length_r;

endmodule

`default_nettype wire
